FILE: sv/abba_pkg.sv
// Shared types and constants of the aligned block bump allocator.
// Used by abba_rem, abba_cfg and aligned_block_bump_allocator; depends on nothing.
`default_nettype none

package abba_pkg;

    // Stack depth default and field widths.
    localparam int unsigned MAX_BLOCKS_DEF = 16;
    localparam int unsigned DATA_W         = 32;
    localparam int unsigned ALIGN_W        = 16;
    localparam int unsigned ACT_W          = 3;
    localparam int unsigned STATUS_W       = 2;
    localparam int unsigned IDX_OUT_W      = 4;
    localparam int unsigned TOTAL_W        = 36;

    // Stream payload widths.
    localparam int unsigned S_TDATA_W = 80;
    localparam int unsigned M_TDATA_W = 112;
    localparam int unsigned M_FIELD_W = IDX_OUT_W + 2 * DATA_W + 1 + TOTAL_W;
    localparam int unsigned M_PAD_W   = M_TDATA_W - M_FIELD_W;

    // Register port.
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_DEFAULT_SIZE = 1'b0;
    localparam logic [DATA_W-1:0] DEFAULT_BLOCK_SIZE_RST = 32'd32768;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_MAKE     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_AT_LEAST = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PUT_BACK = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLOSE    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESET    = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // Remainder unit request and response.
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0]  dividend;
        logic [ALIGN_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic              done;
        logic [ALIGN_W-1:0] remainder;
    } rem_rsp_t;

endpackage

`default_nettype wire

FILE: sv/abba_rem.sv
// Bit-serial remainder unit: 32-bit dividend modulo 16-bit divisor, one bit per cycle.
// Depends on abba_pkg for widths and the request and response structs.
`default_nettype none

module abba_rem (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire abba_pkg::rem_req_t req,
    output abba_pkg::rem_rsp_t      rsp
);

    localparam int unsigned CNT_W = $clog2(abba_pkg::DATA_W);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [abba_pkg::DATA_W-1:0]   dvd_reg, dvd_next;
    logic [abba_pkg::ALIGN_W-1:0]  dvs_reg, dvs_next;
    logic [abba_pkg::ALIGN_W-1:0]  rem_reg, rem_next;
    logic [abba_pkg::ALIGN_W:0]    trial;

    // Shift the next dividend bit into the partial remainder.
    assign trial = {rem_reg, dvd_reg[abba_pkg::DATA_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = abba_pkg::ALIGN_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[abba_pkg::ALIGN_W-1:0];
            end
            dvd_next = {dvd_reg[abba_pkg::DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(abba_pkg::DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

FILE: sv/abba_cfg.sv
// Register port of the allocator: holds the default block size register.
// Depends on abba_pkg for widths, the register index and its reset value.
`default_nettype none

module abba_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [abba_pkg::APB_AW-1:0]   paddr,
    input  wire logic [abba_pkg::APB_DW-1:0]   pwdata,
    output logic      [abba_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output logic      [abba_pkg::DATA_W-1:0]   default_size
);

    logic [abba_pkg::REG_IDX_W-1:0] reg_idx;
    logic [abba_pkg::DATA_W-1:0]    dflt_reg, dflt_next;
    logic                           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[abba_pkg::APB_AW-1:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_comb begin
        dflt_next = dflt_reg;
        prdata    = '0;
        unique case (reg_idx)
            abba_pkg::REG_DEFAULT_SIZE: begin
                prdata = dflt_reg;
                if (wr_en) begin
                    dflt_next = pwdata;
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_reg <= abba_pkg::DEFAULT_BLOCK_SIZE_RST;
        end else begin
            dflt_reg <= dflt_next;
        end
    end

    assign default_size = dflt_reg;

endmodule

`default_nettype wire

FILE: sv/aligned_block_bump_allocator.sv
// Top level of the aligned block bump allocator: sequencer, stack memories, result register.
// Depends on abba_pkg, abba_rem (remainder unit) and abba_cfg (register port).
`default_nettype none

// The allocator keeps a stack of up to MAX_BLOCKS buffer blocks, each with a size and a count
// of free bytes, and hands out space from the top block by bumping its used count after
// padding it up to the requested alignment. Every input transfer carries one action in
// s_tuser and yields exactly one result transfer, whose status travels in m_tuser. Items are
// handled one at a time: s_tready is high only while the sequencer is idle, and a finished
// result waits in the output register, so the next item may be taken before it is drained.
// The alignment padding and the aligned-down partial grant each need a remainder by an
// arbitrary 16-bit value, which one shared bit-serial unit works out. A make space action
// reads the top entry, waits for the padding remainder and places the request in the open
// top block, or opens a new block after all when it does not fit. A make space at least
// checks its request in the same way and grants its fallback size when that fits in what is
// left; when it falls short, a second remainder aligns the grant down. An action that opens
// a new block at once needs no remainder. A put back pops blocks one after another and
// shrinks at most one block. Close, reset and unused action codes go straight to the result.
// Every action also waits while the previous result still sits in the output register. The
// stack memories need no clearing after reset: only entries below the block count are ever
// read. default_block_size sits at byte address 0 of the register port and should be written
// only while the block is idle.

module aligned_block_bump_allocator #(
    parameter int unsigned MAX_BLOCKS = abba_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Input channel.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata: request_bytes [31:0], fallback_bytes [63:32], alignment [79:64]
    input  wire logic [abba_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: action [2:0]
    input  wire logic [abba_pkg::ACT_W-1:0]         s_tuser,
    // Result channel.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata: block_index [3:0], offset [35:4], granted_bytes [67:36], new_block [68],
    //          bytes_in_use [104:69], zero fill [111:105]
    output logic      [abba_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: status [1:0]
    output logic      [abba_pkg::STATUS_W-1:0]      m_tuser,
    // Register port.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [abba_pkg::APB_AW-1:0]        paddr,
    input  wire logic [abba_pkg::APB_DW-1:0]        pwdata,
    output logic      [abba_pkg::APB_DW-1:0]        prdata,
    output logic                                    pready
);

    localparam int unsigned CNTW = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned IDXW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned DW   = abba_pkg::DATA_W;
    localparam int unsigned AW   = abba_pkg::ALIGN_W;
    localparam int unsigned TW   = abba_pkg::TOTAL_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_USED,
        S_PAD,
        S_FIT,
        S_TAKE,
        S_GRANT,
        S_PUSH,
        S_PB_CHECK,
        S_PB_STEP,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    // Latched input item. For put back, req_reg counts down the bytes still to return.
    logic [abba_pkg::ACT_W-1:0] act_reg, act_next;
    logic [DW-1:0]              req_reg, req_next;
    logic [DW-1:0]              fb_reg, fb_next;
    logic [AW-1:0]              align_reg, align_next;

    // Working values of the top block.
    logic [DW-1:0] fr_reg, fr_next;
    logic [DW-1:0] used_reg, used_next;
    logic [AW-1:0] pad_reg, pad_next;

    // Allocator state.
    logic [CNTW-1:0] count_reg, count_next;
    logic            open_reg, open_next;
    logic [TW-1:0]   total_reg, total_next;

    // Result fields collected while the item is worked on.
    logic [abba_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [abba_pkg::IDX_OUT_W-1:0] res_idx_reg, res_idx_next;
    logic [DW-1:0]                  res_off_reg, res_off_next;
    logic [DW-1:0]                  res_granted_reg, res_granted_next;
    logic                           res_fresh_reg, res_fresh_next;

    // Output register.
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [abba_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [abba_pkg::STATUS_W-1:0]  m_tuser_reg, m_tuser_next;

    // Block stack memories and their registered read port.
    logic [DW-1:0]   size_mem [MAX_BLOCKS];
    logic [DW-1:0]   free_mem [MAX_BLOCKS];
    logic [DW-1:0]   rd_size_reg;
    logic [DW-1:0]   rd_free_reg;
    logic            mem_we;
    logic            mem_size_we;
    logic [IDXW-1:0] mem_addr;
    logic [DW-1:0]   mem_size_wdata;
    logic [DW-1:0]   mem_free_wdata;

    // Derived values.
    logic [CNTW-1:0] top_cnt;
    logic [IDXW-1:0] top_idx;
    logic [IDXW-1:0] push_idx;
    logic [DW-1:0]   used_calc;
    logic [DW:0]     need_sum;
    logic [DW-1:0]   off_sum;
    logic [DW-1:0]   want;
    logic [DW-1:0]   new_size;
    logic [DW-1:0]   part_size;
    logic [AW-1:0]   in_align;
    logic [DW-1:0]   default_size;

    abba_pkg::rem_req_t rem_req;
    abba_pkg::rem_rsp_t rem_rsp;

    abba_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .default_size (default_size)
    );

    abba_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rem_req),
        .rsp     (rem_rsp)
    );

    assign top_cnt   = count_reg - CNTW'(1);
    assign top_idx   = top_cnt[IDXW-1:0];
    assign push_idx  = count_reg[IDXW-1:0];
    assign used_calc = rd_size_reg - rd_free_reg;
    assign need_sum  = {1'b0, req_reg} + (DW + 1)'(pad_reg);
    assign off_sum   = used_reg + DW'(pad_reg);
    assign want      = (act_reg == abba_pkg::ACT_MAKE) ? req_reg : fb_reg;
    assign new_size  = (want > default_size) ? want : default_size;
    assign part_size = fr_reg - DW'(rem_rsp.remainder);
    // A zero alignment behaves as alignment one.
    assign in_align  = (s_tdata[79:64] == '0) ? AW'(1) : s_tdata[79:64];

    always_comb begin
        state_next       = state_reg;
        act_next         = act_reg;
        req_next         = req_reg;
        fb_next          = fb_reg;
        align_next       = align_reg;
        fr_next          = fr_reg;
        used_next        = used_reg;
        pad_next         = pad_reg;
        count_next       = count_reg;
        open_next        = open_reg;
        total_next       = total_reg;
        res_status_next  = res_status_reg;
        res_idx_next     = res_idx_reg;
        res_off_next     = res_off_reg;
        res_granted_next = res_granted_reg;
        res_fresh_next   = res_fresh_reg;
        m_tvalid_next    = m_tvalid_reg & ~m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;

        mem_we         = 1'b0;
        mem_size_we    = 1'b0;
        mem_addr       = top_idx;
        mem_size_wdata = new_size;
        mem_free_wdata = '0;

        rem_req.start    = 1'b0;
        rem_req.dividend = used_calc;
        rem_req.divisor  = align_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next         = s_tuser;
                    req_next         = s_tdata[31:0];
                    fb_next          = s_tdata[63:32];
                    align_next       = in_align;
                    res_status_next  = abba_pkg::ST_OK;
                    res_idx_next     = '0;
                    res_off_next     = '0;
                    res_granted_next = '0;
                    res_fresh_next   = 1'b0;
                    unique case (s_tuser) inside
                        abba_pkg::ACT_MAKE, abba_pkg::ACT_AT_LEAST: begin
                            // The read port already holds the top entry: no write
                            // has happened since the previous item finished.
                            if (open_reg && count_reg != '0) begin
                                state_next = S_USED;
                            end else begin
                                state_next = S_PUSH;
                            end
                        end
                        abba_pkg::ACT_PUT_BACK: begin
                            state_next = S_PB_CHECK;
                        end
                        abba_pkg::ACT_CLOSE: begin
                            open_next  = 1'b0;
                            state_next = S_OUT;
                        end
                        abba_pkg::ACT_RESET: begin
                            count_next = '0;
                            open_next  = 1'b0;
                            total_next = '0;
                            state_next = S_OUT;
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_USED: begin
                used_next        = used_calc;
                fr_next          = rd_free_reg;
                rem_req.start    = 1'b1;
                rem_req.dividend = used_calc;
                state_next       = S_PAD;
            end
            S_PAD: begin
                if (rem_rsp.done) begin
                    if (rem_rsp.remainder == '0) begin
                        pad_next = '0;
                    end else begin
                        pad_next = align_reg - rem_rsp.remainder;
                    end
                    state_next = S_FIT;
                end
            end
            S_FIT: begin
                if (act_reg == abba_pkg::ACT_MAKE) begin
                    if (need_sum[DW]) begin
                        // Padding plus request does not fit in 32 bits at all.
                        res_status_next = abba_pkg::ST_OVERFLOW;
                        state_next      = S_OUT;
                    end else if (need_sum[DW-1:0] <= fr_reg) begin
                        mem_we           = 1'b1;
                        mem_free_wdata   = fr_reg - need_sum[DW-1:0];
                        total_next       = total_reg + TW'(need_sum[DW-1:0]);
                        res_idx_next     = abba_pkg::IDX_OUT_W'(top_idx);
                        res_off_next     = off_sum;
                        res_granted_next = req_reg;
                        state_next       = S_OUT;
                    end else begin
                        state_next = S_PUSH;
                    end
                end else begin
                    if (need_sum <= {1'b0, fr_reg}) begin
                        fr_next      = fr_reg - DW'(pad_reg);
                        total_next   = total_reg + TW'(pad_reg);
                        res_idx_next = abba_pkg::IDX_OUT_W'(top_idx);
                        res_off_next = off_sum;
                        state_next   = S_TAKE;
                    end else begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_TAKE: begin
                // fr_reg now holds the free bytes left after padding.
                if (fr_reg >= fb_reg) begin
                    mem_we           = 1'b1;
                    mem_free_wdata   = fr_reg - fb_reg;
                    total_next       = total_reg + TW'(fb_reg);
                    res_granted_next = fb_reg;
                    state_next       = S_OUT;
                end else begin
                    rem_req.start    = 1'b1;
                    rem_req.dividend = fr_reg;
                    state_next       = S_GRANT;
                end
            end
            S_GRANT: begin
                // Grant everything left, aligned down; the remainder stays free.
                if (rem_rsp.done) begin
                    mem_we           = 1'b1;
                    mem_free_wdata   = DW'(rem_rsp.remainder);
                    total_next       = total_reg + TW'(part_size);
                    res_granted_next = part_size;
                    state_next       = S_OUT;
                end
            end
            S_PUSH: begin
                if (count_reg >= CNTW'(MAX_BLOCKS)) begin
                    res_status_next = abba_pkg::ST_FULL;
                end else begin
                    mem_we           = 1'b1;
                    mem_size_we      = 1'b1;
                    mem_addr         = push_idx;
                    mem_size_wdata   = new_size;
                    mem_free_wdata   = new_size - want;
                    count_next       = count_reg + CNTW'(1);
                    open_next        = 1'b1;
                    total_next       = total_reg + TW'(want);
                    res_idx_next     = abba_pkg::IDX_OUT_W'(push_idx);
                    res_off_next     = '0;
                    res_granted_next = want;
                    res_fresh_next   = 1'b1;
                end
                state_next = S_OUT;
            end
            S_PB_CHECK: begin
                // The read port samples the new top entry during this cycle.
                if (req_reg == '0) begin
                    state_next = S_OUT;
                end else if (count_reg == '0) begin
                    res_status_next = abba_pkg::ST_EMPTY;
                    state_next      = S_OUT;
                end else begin
                    state_next = S_PB_STEP;
                end
            end
            S_PB_STEP: begin
                if (req_reg >= used_calc) begin
                    // The whole top block is returned: pop it and close the new top.
                    req_next   = req_reg - used_calc;
                    total_next = total_reg - TW'(used_calc);
                    count_next = top_cnt;
                    open_next  = 1'b0;
                    state_next = S_PB_CHECK;
                end else begin
                    mem_we         = 1'b1;
                    mem_free_wdata = rd_free_reg + req_reg;
                    total_next     = total_reg - TW'(req_reg);
                    req_next       = '0;
                    state_next     = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {abba_pkg::M_PAD_W'(0), total_reg, res_fresh_reg,
                                     res_granted_reg, res_off_reg, res_idx_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        act_reg         <= act_next;
        req_reg         <= req_next;
        fb_reg          <= fb_next;
        align_reg       <= align_next;
        fr_reg          <= fr_next;
        used_reg        <= used_next;
        pad_reg         <= pad_next;
        res_status_reg  <= res_status_next;
        res_idx_reg     <= res_idx_next;
        res_off_reg     <= res_off_next;
        res_granted_reg <= res_granted_next;
        res_fresh_reg   <= res_fresh_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            open_reg     <= 1'b0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            open_reg     <= open_next;
            total_reg    <= total_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Stack memories: one write port, one registered read port at the top entry.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            free_mem[mem_addr] <= mem_free_wdata;
        end
        if (mem_size_we) begin
            size_mem[mem_addr] <= mem_size_wdata;
        end
        rd_size_reg <= size_mem[top_idx];
        rd_free_reg <= free_mem[top_idx];
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for aligned_block_bump_allocator: directed and random actions on the
// input stream, one predicted result per action, register writes between phases.
// Depends on abba_pkg and the allocator RTL only.

module tb;
    import abba_pkg::*;

    localparam int unsigned STACK_DEPTH  = MAX_BLOCKS_DEF;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned HOLD_CYCLES  = 600;
    localparam int unsigned IDLE_PERCENT = 18;
    localparam int unsigned PHASE_ITEMS  = 150;
    localparam int unsigned SETTLE       = 100;
    localparam int unsigned REPORT_LIMIT = 10;

    // Action codes the block does not use; it answers them with an unchanged state.
    localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = ACT_RESET + 1'b1;
    localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = '1;

    // Default block sizes written between the random phases, extremes included.
    localparam logic [DATA_W-1:0] PHASE_SIZES [5] = '{
        32'd1, 32'h8000_0000, 32'd4096, 32'd777, 32'd65536
    };

    // Behaviour of the result side: random stalls, one long hold-off, or always ready.
    typedef enum logic [1:0] {RX_RANDOM, RX_HOLD, RX_STEADY} rx_mode_t;

    // One result transfer, split into its fields.
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [IDX_OUT_W-1:0] blk_index;
        logic [DATA_W-1:0]    offset;
        logic [DATA_W-1:0]    granted;
        logic                 fresh;
        logic [TOTAL_W-1:0]   in_use;
    } grant_t;

    // The scoreboard carries its own copy of the block stack and replays every accepted
    // action on it, queueing the grant that the block has to return for it.
    class grant_scoreboard;
        logic [DATA_W-1:0]  blk_size [STACK_DEPTH];
        logic [DATA_W-1:0]  blk_free [STACK_DEPTH];
        int unsigned        blk_count = 0;
        bit                 top_open = 1'b0;
        logic [TOTAL_W-1:0] in_use = '0;
        logic [DATA_W-1:0]  dflt_size = DEFAULT_BLOCK_SIZE_RST;
        grant_t             awaited_grants [$];
        int unsigned        failures = 0;

        // Opens a block able to hold want bytes; fails only when the stack is full.
        function bit push_block(logic [63:0] want);
            logic [63:0] blk_bytes;
            blk_bytes = (want > 64'(dflt_size)) ? want : 64'(dflt_size);
            if (blk_count >= STACK_DEPTH)
                return 1'b0;
            blk_size[blk_count] = blk_bytes[DATA_W-1:0];
            blk_free[blk_count] = DATA_W'(blk_bytes - want);
            blk_count++;
            top_open = 1'b1;
            in_use = in_use + TOTAL_W'(want);
            return 1'b1;
        endfunction

        function void note_action(logic [ACT_W-1:0] act, logic [DATA_W-1:0] req,
                                  logic [DATA_W-1:0] fb, logic [ALIGN_W-1:0] align);
            grant_t            g;
            logic [63:0]       al, fr, used, pad, want, bytes, grant_size;
            logic [DATA_W-1:0] used32;
            int unsigned       t;
            bit                placed, fail;
            g = '0;
            placed = 1'b0;
            fail = 1'b0;
            // A zero alignment behaves as no alignment at all.
            al = (align == 0) ? 64'd1 : 64'(align);
            if (act == ACT_MAKE || act == ACT_AT_LEAST) begin
                if (top_open && blk_count > 0) begin
                    t = blk_count - 1;
                    fr = 64'(blk_free[t]);
                    used32 = blk_size[t] - blk_free[t];
                    used = 64'(used32);
                    pad = used % al;
                    if (pad != 0)
                        pad = al - pad;
                    if (act == ACT_MAKE) begin
                        if (pad + 64'(req) > 64'hFFFF_FFFF) begin
                            g.status = ST_OVERFLOW;
                            fail = 1'b1;
                        end else if (pad + 64'(req) <= fr) begin
                            blk_free[t] = DATA_W'(fr - pad - 64'(req));
                            in_use = in_use + TOTAL_W'(pad + 64'(req));
                            g.blk_index = IDX_OUT_W'(t);
                            g.offset = DATA_W'(used + pad);
                            g.granted = req;
                            placed = 1'b1;
                        end
                    end else if (64'(req) + pad <= fr) begin
                        // Grant the fallback when it fits, else whatever is left, aligned down.
                        fr = fr - pad;
                        grant_size = (fr >= 64'(fb)) ? 64'(fb) : fr - (fr % al);
                        blk_free[t] = DATA_W'(fr - grant_size);
                        in_use = in_use + TOTAL_W'(pad) + TOTAL_W'(grant_size);
                        g.blk_index = IDX_OUT_W'(t);
                        g.offset = DATA_W'(used + pad);
                        g.granted = DATA_W'(grant_size);
                        placed = 1'b1;
                    end
                end
                if (!placed && !fail) begin
                    want = (act == ACT_MAKE) ? 64'(req) : 64'(fb);
                    if (push_block(want)) begin
                        g.blk_index = IDX_OUT_W'(blk_count - 1);
                        g.offset = '0;
                        g.granted = DATA_W'(want);
                        g.fresh = 1'b1;
                    end else begin
                        g.status = ST_FULL;
                    end
                end
            end else if (act == ACT_PUT_BACK) begin
                // Pop emptied blocks from the top; running out of blocks is an error, but
                // whatever was popped stays popped.
                bytes = 64'(req);
                while (bytes != 0) begin
                    if (blk_count == 0) begin
                        g.status = ST_EMPTY;
                        break;
                    end
                    t = blk_count - 1;
                    used32 = blk_size[t] - blk_free[t];
                    if (bytes >= 64'(used32)) begin
                        bytes = bytes - 64'(used32);
                        in_use = in_use - TOTAL_W'(used32);
                        blk_count--;
                        top_open = 1'b0;
                    end else begin
                        blk_free[t] = blk_free[t] + DATA_W'(bytes);
                        in_use = in_use - TOTAL_W'(bytes);
                        bytes = 0;
                    end
                end
            end else if (act == ACT_CLOSE) begin
                top_open = 1'b0;
            end else if (act == ACT_RESET) begin
                blk_count = 0;
                top_open = 1'b0;
                in_use = '0;
            end
            if (g.status != ST_OK) begin
                g.blk_index = '0;
                g.offset = '0;
                g.granted = '0;
                g.fresh = 1'b0;
            end
            g.in_use = in_use;
            awaited_grants = {awaited_grants, g};
        endfunction

        function void flag_mismatch(string what, grant_t want, grant_t got);
            failures++;
            if (failures <= REPORT_LIMIT) begin
                $display("%s: expected st=%0d idx=%0d off=%h grant=%h new=%0d use=%h",
                         what, want.status, want.blk_index, want.offset, want.granted,
                         want.fresh, want.in_use);
                $display("    got st=%0d idx=%0d off=%h grant=%h new=%0d use=%h",
                         got.status, got.blk_index, got.offset, got.granted, got.fresh,
                         got.in_use);
            end
        endfunction

        function void check_grant(logic [STATUS_W-1:0] status, logic [M_TDATA_W-1:0] data);
            grant_t got, want;
            got.status    = status;
            got.blk_index = data[3:0];
            got.offset    = data[35:4];
            got.granted   = data[67:36];
            got.fresh     = data[68];
            got.in_use    = data[104:69];
            if (awaited_grants.size() == 0) begin
                flag_mismatch("result transfer with nothing awaited", '0, got);
                return;
            end
            want = awaited_grants.pop_front();
            if (got.status !== want.status || got.blk_index !== want.blk_index ||
                got.offset !== want.offset || got.granted !== want.granted ||
                got.fresh !== want.fresh || got.in_use !== want.in_use)
                flag_mismatch("result mismatch", want, got);
        endfunction
    endclass

    // Clock, reset and every input of the block start at known values.
    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [ACT_W-1:0]       s_tuser  = ACT_MAKE;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_AW-1:0]      paddr    = '0;
    logic [APB_DW-1:0]      pwdata   = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    grant_scoreboard sb = new;
    rx_mode_t        rx_mode = RX_RANDOM;
    bit              tx_steady = 1'b0;
    int unsigned     cycle_count = 0;
    int unsigned     hold_seen = 0;

    aligned_block_bump_allocator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // Watchdog: a run that hangs on a handshake ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side. In hold mode the receiver refuses transfers until hold_seen reaches
    // HOLD_CYCLES, so that the finished result sits in the output register and the block stops
    // taking input; afterwards it falls back to random stalls.
    always @(posedge aclk) begin
        if (rx_mode == RX_HOLD && hold_seen < HOLD_CYCLES) begin
            hold_seen <= hold_seen + 1;
            m_tready <= 1'b0;
        end else if (rx_mode == RX_STEADY) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Values are sampled at the clock edge, before any update that the edge itself causes.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_grant(m_tuser, m_tdata);
    end

    // Offers one action and returns in the time step of the edge at which it was accepted.
    // s_tvalid is left high on purpose: the next call either keeps it high with new data or
    // lowers it for a gap, so the signal never gets two assignments in one step.
    task automatic send_item(logic [ACT_W-1:0] act, logic [DATA_W-1:0] req,
                             logic [DATA_W-1:0] fb, logic [ALIGN_W-1:0] align);
        while (!tx_steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {align, fb, req};
        do
            @(posedge aclk);
        while (s_tready !== 1'b1);
        sb.note_action(act, req, fb, align);
    endtask

    // Sizes lean towards small values so that blocks fill gradually, with whole-range values,
    // zero and values near the top of the range mixed in.
    function automatic logic [DATA_W-1:0] rand_size();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return DATA_W'($urandom_range(256));
        else if (pick < 80)
            return DATA_W'($urandom_range(65536));
        else if (pick < 90)
            return $urandom();
        else if (pick < 95)
            return '0;
        return 32'hFFFF_FFFF - DATA_W'($urandom_range(3));
    endfunction

    function automatic logic [ALIGN_W-1:0] rand_align();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return ALIGN_W'(1) << $urandom_range(12);
        else if (pick < 80)
            return ALIGN_W'($urandom_range(100, 1));
        else if (pick < 90)
            return ALIGN_W'($urandom());
        else if (pick < 95)
            return '0;
        return '1;
    endfunction

    function automatic logic [DATA_W-1:0] rand_put_back();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return DATA_W'($urandom_range(512));
        else if (pick < 85)
            return DATA_W'($urandom_range(70000));
        return $urandom();
    endfunction

    // Mostly allocations with some put backs, so the stack grows, fills and drains again;
    // closes, resets and the spare action codes are sprinkled in as noise.
    task automatic send_random_item();
        int unsigned      pick;
        logic [ACT_W-1:0] act;
        pick = $urandom_range(99);
        if (pick < 40)
            act = ACT_MAKE;
        else if (pick < 65)
            act = ACT_AT_LEAST;
        else if (pick < 85)
            act = ACT_PUT_BACK;
        else if (pick < 92)
            act = ACT_CLOSE;
        else if (pick < 95)
            act = ACT_RESET;
        else
            act = ACT_W'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
        send_item(act, (act == ACT_PUT_BACK) ? rand_put_back() : rand_size(),
                  rand_size(), rand_align());
    endtask

    // Stops offering input and waits until every awaited result has been taken, then lets the
    // block settle so that a register write finds it idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.awaited_grants.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Register write: a setup phase, then the access phase until pready is seen high.
    task automatic write_default_size(logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DEFAULT_SIZE, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.dflt_size = value;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, run with the default block size from reset.
        send_item(ACT_MAKE, 32'd100, 32'd0, 16'd1);                 // opens the first block
        send_item(ACT_MAKE, 32'd10, 32'd0, 16'd16);                 // padded placement
        send_item(ACT_MAKE, 32'd0, 32'd0, 16'd0);                   // zero alignment
        send_item(ACT_MAKE, 32'hFFFF_FFFF, 32'd0, 16'hFFFF);        // padding overflows
        send_item(ACT_AT_LEAST, 32'd8, 32'hFFFF_FFFF, 16'd64);      // partial grant, aligned down
        send_item(ACT_MAKE, 32'd40000, 32'd0, 16'd8);               // block above default size
        send_item(ACT_AT_LEAST, 32'd1, 32'd3, 16'd1);               // full block, fallback opens one
        send_item(ACT_AT_LEAST, 32'd2, 32'd5, 16'd2);               // unaligned fallback fits
        send_item(ACT_CLOSE, 32'd0, 32'd0, 16'd1);
        send_item(ACT_AT_LEAST, 32'd16, 32'd7, 16'd4);              // fallback below the minimum
        send_item(ACT_AT_LEAST, 32'd0, 32'd0, 16'h8000);            // pad eats the whole block
        send_item(ACT_MAKE, 32'hFFFF_FFFF, 32'd0, 16'd1);           // largest block
        send_item(ACT_PUT_BACK, 32'd5, 32'd0, 16'd1);               // partial return
        send_item(ACT_PUT_BACK, 32'hFFFF_FFFF, 32'd0, 16'd1);       // pops the largest block, shrinks the next
        send_item(ACT_PUT_BACK, 32'd0, 32'd0, 16'd1);
        send_item(ACT_MAKE, 32'd64, 32'hFFFF_FFFF, 16'd3);
        send_item(ACT_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(ACT_SPARE_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(ACT_SPARE_FIRST + 1'b1, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 16'h0F0F);
        send_item(ACT_SPARE_LAST, 32'd1, 32'd2, 16'd3);
        send_item(ACT_MAKE, 32'd1, 32'd0, 16'hFFFF);
        send_item(ACT_PUT_BACK, 32'd1, 32'd0, 16'd1);               // pops exactly one block
        drain();

        // Random phases, one default block size each. The second phase holds the receiver off
        // for a long stretch; the third runs both sides without any idling.
        for (int p = 0; p < 5; p++) begin
            write_default_size(PHASE_SIZES[p]);
            if (p == 1)
                rx_mode <= RX_HOLD;
            else if (p == 2)
                rx_mode <= RX_STEADY;
            else
                rx_mode <= RX_RANDOM;
            tx_steady = (p == 2);
            repeat (PHASE_ITEMS) send_random_item();
            drain();
        end

        rx_mode <= RX_RANDOM;
        repeat (SETTLE) @(posedge aclk);
        if (sb.failures == 0 && sb.awaited_grants.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
